// File: src/kti_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kti_pkg
// shared constants and request codes for the keyframe track interpolator
// ----------------------------------------------------------------------------
package kti_pkg;
   localparam int unsigned MAX_KEYS_DEF = 16;
   localparam int unsigned TIME_W       = 32;
   localparam int unsigned POS_W        = 32;

   localparam logic [2:0] REQ_ADD    = 3'd0;
   localparam logic [2:0] REQ_DELETE = 3'd1;
   localparam logic [2:0] REQ_CHANGE = 3'd2;
   localparam logic [2:0] REQ_EXISTS = 3'd3;
   localparam logic [2:0] REQ_INTERP = 3'd4;

   localparam logic [1:0] CSR_REST_X = 2'd0;
   localparam logic [1:0] CSR_REST_Y = 2'd1;
   localparam logic [1:0] CSR_REST_Z = 2'd2;

   // divider job
   typedef struct packed {
      logic [95:0] mag;
      logic [31:0] den;
   } div_req_type;
endpackage
`default_nettype wire

// File: src/kti_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kti_ram
// generic single-port-write, one-read synchronous ram, registered read
// ----------------------------------------------------------------------------
module kti_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [$clog2(DEPTH)-1:0] wr_addr,
   input  wire [WIDTH-1:0]         wr_data,
   input  wire [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]        rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: src/kti_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kti_div
// restoring divider, one quotient bit per cycle, 64-bit dividend by 32 bits
// ----------------------------------------------------------------------------
module kti_div (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   input  wire  [63:0] dividend,
   input  wire  [31:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [63:0] q_ff, q_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [32:0] trial;

   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      trial   = {rem_ff[31:0], q_ff[63]};
      done    = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 7'd0;
         q_in    = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            q_in   = {q_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done    = 1'b1;
         end
      end
   end

   assign quotient = q_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end
endmodule
`default_nettype wire

// File: src/keyframe_track_interpolator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyframe_track_interpolator
// time-sorted keyframe table in two rams with add, delete, change, exists and
// piecewise linear interpolation
// ----------------------------------------------------------------------------
// channel | direction | handshake           | payload
// req     | in        | req_valid/req_ready | req_type key_time in_x in_y in_z
// rsp     | out       | rsp_valid/rsp_ready | ok out_x out_y out_z
// csr     | in        | csr_valid/csr_ready | csr_index csr_data
//
// one request at a time: a linear search reads and compares one key after
// another, an insert or delete moves one key per read and write, and an
// interpolation runs three divisions, one per axis, on the shared divider.
// reset clears the state, key count, response valid and rest registers; the rams need no clearing.
// a stalled response holds in its register; the next request is taken once
// it has been transferred.
module keyframe_track_interpolator #(
   parameter int unsigned MAX_KEYS = kti_pkg::MAX_KEYS_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [2:0]  req_type,
   input  wire  [31:0] key_time,
   input  wire  [31:0] in_x,
   input  wire  [31:0] in_y,
   input  wire  [31:0] in_z,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic        ok,
   output logic [31:0] out_x,
   output logic [31:0] out_y,
   output logic [31:0] out_z,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_index,
   input  wire  [31:0] csr_data
);
   localparam int unsigned AW = $clog2(MAX_KEYS);
   localparam int unsigned CW = $clog2(MAX_KEYS + 1);
   localparam logic [CW-1:0] FULL = CW'(MAX_KEYS);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SRCH   = 4'd1;
   localparam logic [3:0] ST_SCMP   = 4'd2;
   localparam logic [3:0] ST_DEC    = 4'd3;
   localparam logic [3:0] ST_MVRD   = 4'd4;
   localparam logic [3:0] ST_MVWR   = 4'd5;
   localparam logic [3:0] ST_FIN    = 4'd6;
   localparam logic [3:0] ST_RD0    = 4'd7;
   localparam logic [3:0] ST_RD1    = 4'd8;
   localparam logic [3:0] ST_DIVGO  = 4'd9;
   localparam logic [3:0] ST_DIVW   = 4'd10;
   localparam logic [3:0] ST_RSP    = 4'd11;
   localparam logic [3:0] ST_PREV   = 4'd12;

   logic [3:0]    st_ff, st_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] j_ff, j_in;
   logic [2:0]    rt_ff, rt_in;
   logic [31:0]   t_ff, t_in;
   logic [95:0]   ip_ff, ip_in;
   logic [31:0]   rx_ff, ry_ff, rz_ff;
   logic          found_ff, found_in;
   logic          ok_ff, ok_in;
   logic [95:0]   o_ff, o_in;
   logic [95:0]   p0_ff, p0_in;
   logic [95:0]   p1_ff, p1_in;
   logic [31:0]   t0_ff, t0_in;
   logic [1:0]    ax_ff, ax_in;
   logic          rv_ff, rv_in;
   logic          del_ff, del_in;

   // ram and divider ports
   logic          we;
   logic [AW-1:0] wa, ra;
   logic [31:0]   wt, rt_q;
   logic [95:0]   wp, rp_q;
   logic          done;
   logic [63:0]   quo;
   logic          dstart;
   logic [63:0]   dnum;
   logic [31:0]   dden;
   logic [32:0]   dlt;
   logic [32:0]   dmag;
   logic [31:0]   p0a, p1a, oa;

   kti_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_time (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wt),
      .rd_addr(ra), .rd_data(rt_q));
   kti_ram #(.WIDTH(96), .DEPTH(MAX_KEYS)) u_pos (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wp),
      .rd_addr(ra), .rd_data(rp_q));
   kti_div u_div (
      .clock(clock), .reset(reset), .start(dstart), .dividend(dnum),
      .divisor(dden), .done(done), .quotient(quo));

   assign req_ready = (st_ff == ST_IDLE) && !rv_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rv_ff;
   assign ok        = ok_ff;
   assign out_x     = o_ff[95:64];
   assign out_y     = o_ff[63:32];
   assign out_z     = o_ff[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_ff <= '0;
         ry_ff <= '0;
         rz_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            kti_pkg::CSR_REST_X: rx_ff <= csr_data;
            kti_pkg::CSR_REST_Y: ry_ff <= csr_data;
            kti_pkg::CSR_REST_Z: rz_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (ax_ff)
         2'd0:    begin p0a = p0_ff[95:64]; p1a = p1_ff[95:64]; end
         2'd1:    begin p0a = p0_ff[63:32]; p1a = p1_ff[63:32]; end
         default: begin p0a = p0_ff[31:0];  p1a = p1_ff[31:0];  end
      endcase
      dlt  = {p1a[31], p1a} - {p0a[31], p0a};
      dmag = dlt[32] ? (~dlt + 33'd1) : dlt;
      dnum = 64'(dmag) * 64'(t_ff - t0_ff);
      dden = rt_q - t0_ff;
      oa   = dlt[32] ? (p0a - quo[31:0]) : (p0a + quo[31:0]);
   end

   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; idx_in = idx_ff; j_in = j_ff;
      rt_in = rt_ff; t_in = t_ff; ip_in = ip_ff; found_in = found_ff;
      ok_in = ok_ff; o_in = o_ff; p0_in = p0_ff; p1_in = p1_ff;
      t0_in = t0_ff; ax_in = ax_ff; rv_in = rv_ff; del_in = del_ff;
      we = 1'b0; wa = '0; wt = t_ff; wp = ip_ff; ra = AW'(idx_ff);
      dstart = 1'b0;
      if (rv_ff && rsp_ready) begin
         rv_in = 1'b0;
      end
      case (st_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               rt_in = req_type; t_in = key_time; ip_in = {in_x, in_y, in_z};
               idx_in = '0; ok_in = 1'b0; o_in = '0; found_in = 1'b0;
               st_in = ST_SRCH;
            end
         end
         ST_SRCH: begin
            ra = AW'(idx_ff);
            if (idx_ff >= cnt_ff) begin
               st_in = ST_DEC;
            end else begin
               st_in = ST_SCMP;
            end
         end
         ST_SCMP: begin
            // time and position of key idx on the ram outputs
            if (rt_q < t_ff) begin
               idx_in = idx_ff + 1'b1;
               t0_in  = rt_q;
               p0_in  = rp_q;
               st_in  = ST_SRCH;
            end else begin
               found_in = (rt_q == t_ff);
               p1_in    = rp_q;
               st_in    = ST_DEC;
            end
         end
         ST_DEC: begin
            st_in = ST_RSP;
            del_in = 1'b0;
            case (rt_ff)
               kti_pkg::REQ_ADD: begin
                  if (!found_ff && cnt_ff != FULL) begin
                     ip_in = (idx_ff < cnt_ff) ? p1_ff : {rx_ff, ry_ff, rz_ff};
                     j_in = cnt_ff; ok_in = 1'b1;
                     st_in = (cnt_ff == idx_ff) ? ST_FIN : ST_MVRD;
                  end
               end
               kti_pkg::REQ_DELETE: begin
                  if (found_ff) begin
                     del_in = 1'b1; j_in = idx_ff; ok_in = 1'b1;
                     st_in = (idx_ff + 1'b1 >= cnt_ff) ? ST_FIN : ST_MVRD;
                  end
               end
               kti_pkg::REQ_CHANGE: begin
                  if (found_ff) begin
                     we = 1'b1; wa = AW'(idx_ff); ok_in = 1'b1;
                  end else if (cnt_ff != FULL) begin
                     j_in = cnt_ff; ok_in = 1'b1;
                     st_in = (cnt_ff == idx_ff) ? ST_FIN : ST_MVRD;
                  end
               end
               kti_pkg::REQ_EXISTS: ok_in = found_ff;
               kti_pkg::REQ_INTERP: begin
                  if (cnt_ff != '0) begin
                     ok_in = 1'b1;
                     if (idx_ff >= cnt_ff) begin
                        ra = AW'(cnt_ff - 1'b1); st_in = ST_PREV;
                     end else if (idx_ff == '0 || found_ff) begin
                        o_in = p1_ff;
                     end else begin
                        ra = AW'(idx_ff); ax_in = 2'd0; st_in = ST_RD1;
                     end
                  end
               end
               default: ;
            endcase
         end
         ST_PREV: begin
            o_in = rp_q; st_in = ST_RSP;
         end
         ST_MVRD: begin
            // insert reads j-1 into j, delete reads j+1 into j
            ra = del_ff ? AW'(j_ff + 1'b1) : AW'(j_ff - 1'b1);
            st_in = ST_MVWR;
         end
         ST_MVWR: begin
            we = 1'b1; wa = AW'(j_ff); wt = rt_q; wp = rp_q;
            if (del_ff) begin
               j_in  = j_ff + 1'b1;
               st_in = (j_ff + 2'd2 >= cnt_ff) ? ST_FIN : ST_MVRD;
            end else begin
               j_in  = j_ff - 1'b1;
               st_in = (j_ff - 1'b1 == idx_ff) ? ST_FIN : ST_MVRD;
            end
         end
         ST_FIN: begin
            if (del_ff) begin
               cnt_in = cnt_ff - 1'b1;
            end else begin
               we = 1'b1; wa = AW'(idx_ff);
               cnt_in = cnt_ff + 1'b1;
            end
            st_in = ST_RSP;
         end
         ST_RD1: begin
            ra = AW'(idx_ff); st_in = ST_DIVGO;
         end
         ST_DIVGO: begin
            ra = AW'(idx_ff); dstart = 1'b1; st_in = ST_DIVW;
         end
         ST_DIVW: begin
            ra = AW'(idx_ff);
            if (done) begin
               case (ax_ff)
                  2'd0:    o_in[95:64] = oa;
                  2'd1:    o_in[63:32] = oa;
                  default: o_in[31:0]  = oa;
               endcase
               if (ax_ff == 2'd2) begin
                  st_in = ST_RSP;
               end else begin
                  ax_in = ax_ff + 2'd1; st_in = ST_DIVGO;
               end
            end
         end
         ST_RSP: begin
            rv_in = 1'b1; st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_IDLE;
         cnt_ff <= '0;
         rv_ff  <= 1'b0;
      end else begin
         st_ff  <= st_in;
         cnt_ff <= cnt_in;
         rv_ff  <= rv_in;
      end
      idx_ff <= idx_in; j_ff <= j_in; rt_ff <= rt_in; t_ff <= t_in;
      ip_ff <= ip_in; found_ff <= found_in; ok_ff <= ok_in; o_ff <= o_in;
      p0_ff <= p0_in; p1_ff <= p1_in; t0_ff <= t0_in; ax_ff <= ax_in;
      del_ff <= del_in;
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL) else $error("key count beyond table size");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> !req_ready) else $error("request taken with response pending");
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (st_ff != ST_FIN) |=> $stable(cnt_ff)) else $error("count moved outside commit");
endmodule
`default_nettype wire
